FILE: hw/rtl/capped_closed_row_policy_macros.svh
// assertion macros for the capped closed-row policy block
`ifndef CAPPED_CLOSED_ROW_POLICY_MACROS_SVH
`define CAPPED_CLOSED_ROW_POLICY_MACROS_SVH

// same-cycle implication, checked out of reset
`define CCRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CCRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ccrp_pkg.sv
// shared types and codes of the capped closed-row policy block
package ccrp_pkg;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_OTHER  = 3'd2,
    CMD_CLOSE  = 3'd3,
    CMD_IGNORE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    SCOPE_BANK      = 2'd0,
    SCOPE_SAME_BANK = 2'd1,
    SCOPE_RANK      = 2'd2
  } scope_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_RD_AP = 2'd1,
    ACT_WR_AP = 2'd2,
    ACT_PRE   = 2'd3
  } action_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_e;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCESS_CAP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AP_OK      = 4'd1;

  typedef struct packed {
    logic accept;  // latch the item and read its counter
    logic exec;    // update counters and load the result register
  } ctrl_cmd_t;

endpackage

FILE: hw/rtl/ccrp_ctrl.sv
// controller: item sequencing and result register handshake
module ccrp_ctrl
  import ccrp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_stall_o   = 1'b1;
    out_valid_d  = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait for the result register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/ccrp_dp.sv
// datapath: counter memory, valid bits, cap compare and action select
module ccrp_dp
  import ccrp_pkg::*;
#(
  parameter int RANKS           = 4,
  parameter int BANK_GROUPS     = 8,
  parameter int BANKS_PER_GROUP = 4,
  parameter int COUNT_BITS      = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_cmd_t       ctrl_i,
  input  logic [2:0]      cmd_i,
  input  logic [1:0]      close_scope_i,
  input  logic [1:0]      rank_i,
  input  logic [2:0]      bank_group_i,
  input  logic [1:0]      bank_i,
  input  logic [15:0]     access_cap_i,
  input  logic            ap_ok_i,
  output logic [1:0]      action_o
);

  localparam int FLAT  = RANKS * BANK_GROUPS * BANKS_PER_GROUP;
  localparam int IDX_W = (FLAT > 1) ? $clog2(FLAT) : 1;
  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [COUNT_BITS-1:0] mem [FLAT];
  logic [COUNT_BITS-1:0] rd_q;
  logic [FLAT-1:0]       valid_q, valid_d;

  logic [2:0]       cmd_q;
  logic [1:0]       scope_q;
  logic [1:0]       rank_q, bank_q;
  logic [2:0]       bg_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] idx_in;
  action_e          action_q, action_d;

  logic                  in_range, is_access, hit, do_write;
  logic [COUNT_BITS-1:0] cur, inc;

  assign idx_in = IDX_W'(32'(bank_i) + 32'(bank_group_i) * BANKS_PER_GROUP
                  + 32'(rank_i) * (BANKS_PER_GROUP * BANK_GROUPS));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q   <= cmd_i;
      scope_q <= close_scope_i;
      rank_q  <= rank_i;
      bg_q    <= bank_group_i;
      bank_q  <= bank_i;
      idx_q   <= idx_in;
    end
    if (ctrl_i.exec) begin
      action_q <= action_d;
    end
  end

  // counter memory, registered read on accept, write back on exec of an in-range access below the cap
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      rd_q <= mem[idx_in];
    end
    if (do_write) begin
      mem[idx_q] <= inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_range  = (32'(rank_q) < RANKS) && (32'(bg_q) < BANK_GROUPS)
                     && (32'(bank_q) < BANKS_PER_GROUP);
  assign is_access = (cmd_q == CMD_READ) || (cmd_q == CMD_WRITE) || (cmd_q == CMD_OTHER);

  // an entry without its valid bit reads as zero
  assign cur = valid_q[idx_q] ? rd_q : '0;
  assign inc = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + 1'b1;
  assign hit = CMP_W'(inc) >= CMP_W'(access_cap_i);

  assign do_write = ctrl_i.exec && is_access && in_range && !hit;

  always_comb begin
    action_d = ACT_NONE;
    if (is_access && in_range && hit) begin
      priority if (ap_ok_i && (cmd_q == CMD_READ)) begin
        action_d = ACT_RD_AP;
      end else if (ap_ok_i && (cmd_q == CMD_WRITE)) begin
        action_d = ACT_WR_AP;
      end else begin
        action_d = ACT_PRE;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.exec) begin
      if (cmd_q == CMD_CLOSE) begin
        // scope decode per entry; entries of a missing rank never match
        for (int r = 0; r < RANKS; r++) begin
          for (int g = 0; g < BANK_GROUPS; g++) begin
            for (int b = 0; b < BANKS_PER_GROUP; b++) begin
              if (32'(rank_q) == r) begin
                unique case (scope_q)
                  SCOPE_BANK: begin
                    if ((32'(bg_q) == g) && (32'(bank_q) == b)) begin
                      valid_d[b + g * BANKS_PER_GROUP
                              + r * BANKS_PER_GROUP * BANK_GROUPS] = 1'b0;
                    end
                  end
                  SCOPE_SAME_BANK: begin
                    if (32'(bank_q) == b) begin
                      valid_d[b + g * BANKS_PER_GROUP
                              + r * BANKS_PER_GROUP * BANK_GROUPS] = 1'b0;
                    end
                  end
                  default: begin
                    valid_d[b + g * BANKS_PER_GROUP
                            + r * BANKS_PER_GROUP * BANK_GROUPS] = 1'b0;
                  end
                endcase
              end
            end
          end
        end
      end else if (is_access && in_range) begin
        // reaching the cap clears the counter
        valid_d[idx_q] = !hit;
      end
    end
  end

  assign action_o = action_q;

endmodule

FILE: hw/rtl/capped_closed_row_policy.sv
// capped closed-row policy: top level with configuration registers
//
// Input channel (in_valid_i / in_stall_o): one beat per issued DRAM command
// with cmd, close scope, rank, bank group and bank. Output channel
// (out_valid_o / out_stall_i): one beat per command carrying the action
// (unchanged, read or write with auto-precharge, priority precharge).
// Configuration channel (cfg_valid_i / cfg_ready_o): index 0 sets the
// access cap, index 1 the auto-precharge support bit; always ready.
// Each command first reads the bank's counter from the counter memory,
// then updates it and loads the result register, so a new command is
// accepted only once the previous one has executed, and its action is
// loaded into the result register when it executes. Close commands clear
// counters of one bank, one bank in every bank group, or a whole rank at
// once through per-entry valid bits.
// Reset clears all counters at once (valid bits), sets the cap to one and
// enables auto-precharge. While the receiver stalls, the result is held
// and one further command can be accepted and read; it then waits until
// the result register is taken.
module capped_closed_row_policy
  import ccrp_pkg::*;
#(
  parameter int RANKS           = 4,
  parameter int BANK_GROUPS     = 8,
  parameter int BANKS_PER_GROUP = 4,
  parameter int COUNT_BITS      = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           cmd_i,
  input  logic [1:0]           close_scope_i,
  input  logic [1:0]           rank_i,
  input  logic [2:0]           bank_group_i,
  input  logic [1:0]           bank_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           action_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

`include "capped_closed_row_policy_macros.svh"

  ctrl_cmd_t   ctrl_cmd;
  logic [15:0] access_cap_q;
  logic        ap_ok_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_cap_q <= 16'd1;
      ap_ok_q      <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_ACCESS_CAP) begin
        access_cap_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_AP_OK) begin
        ap_ok_q <= cfg_data_i[0];
      end
    end
  end

  ccrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (ctrl_cmd)
  );

  ccrp_dp #(
    .RANKS           (RANKS),
    .BANK_GROUPS     (BANK_GROUPS),
    .BANKS_PER_GROUP (BANKS_PER_GROUP),
    .COUNT_BITS      (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl_cmd),
    .cmd_i         (cmd_i),
    .close_scope_i (close_scope_i),
    .rank_i        (rank_i),
    .bank_group_i  (bank_group_i),
    .bank_i        (bank_i),
    .access_cap_i  (access_cap_q),
    .ap_ok_i       (ap_ok_q),
    .action_o      (action_o)
  );

  `CCRP_ASSERT_NOW(a_accept_exec_excl, ctrl_cmd.accept, !ctrl_cmd.exec, "accept during exec")
  `CCRP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "no busy after beat")
  `CCRP_ASSERT_NEXT(a_result_after_exec, ctrl_cmd.exec, out_valid_o, "exec without result")

endmodule
